// File: sv/mft_pkg.sv
// shared widths, constants and types of the motor feedback tracker
package mft_pkg;

   localparam int ANGLE_W        = 13;
   localparam int COUNTS_PER_REV = 8192;
   localparam int CPR_SHIFT      = $clog2(COUNTS_PER_REV);
   localparam int RAW_W          = 16;
   localparam int TEMP_W         = 8;
   localparam int POS_W          = 48;
   localparam int SPD_W          = 35;
   localparam int CUR_W          = 23;
   localparam int LEAD_W         = 24;
   localparam int BAND_W         = 8;
   localparam int BAND_SHIFT     = 16;
   localparam int CSR_INDEX_W    = 2;
   localparam int CSR_DATA_W     = LEAD_W;
   localparam int REQ_DATA_W     = 136;
   localparam int RSP_DATA_W     = 120;

   localparam int DELTA_W        = ANGLE_W + 2;
   localparam int DELTA_MUL_W    = DELTA_W + 7;
   localparam int UNWRAP_PCT     = 66;
   localparam int PCT            = 100;
   localparam int SMAG_W         = RAW_W + 1;
   localparam int PPROD_W        = DELTA_W + LEAD_W;
   localparam int SPROD_W        = SMAG_W + LEAD_W;
   localparam int INC_W          = PPROD_W + 2 - CPR_SHIFT;
   localparam int CURRENT_SCALE  = 80;

   // divide by 60 as a shift by 2 and a two-part reciprocal divide by 15
   localparam int DIV_PRE_SHIFT  = 2;
   localparam int DIV_BASE       = 15;
   localparam int DIV_Y_W        = SPROD_W - DIV_PRE_SHIFT;
   localparam int DIV_LO_W       = 20;
   localparam int DIV_HI_W       = DIV_Y_W - DIV_LO_W;
   localparam int DIV_HI_Q_W     = 16;
   localparam int DIV_REM_W      = 4;
   localparam int DIV_HI_RECIP   = 1118482;
   localparam int DIV_HI_RECIP_W = 21;
   localparam int DIV_HI_SHIFT   = 24;
   localparam int DIV_LO_RECIP   = 17895698;
   localparam int DIV_LO_RECIP_W = 25;
   localparam int DIV_LO_SHIFT   = 28;

   localparam logic [CSR_INDEX_W-1:0] CSR_LEAD      = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_POS_BAND  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPD_BAND  = 2'd2;

   localparam logic [LEAD_W-1:0] LEAD_RESET     = 24'd1625293;
   localparam logic [BAND_W-1:0] POS_BAND_RESET = 8'd5;
   localparam logic [BAND_W-1:0] SPD_BAND_RESET = 8'd10;

   typedef struct packed {
      logic [LEAD_W-1:0] lead;
      logic [BAND_W-1:0] pos_band;
      logic [BAND_W-1:0] spd_band;
   } cfg_type;

   typedef struct packed {
      logic                    mode;
      logic                    delta_neg;
      logic [DELTA_W-1:0]      delta_mag;
      logic                    speed_neg;
      logic [SMAG_W-1:0]       speed_mag;
      logic signed [RAW_W-1:0] raw_current;
      logic [TEMP_W-1:0]       temperature;
      logic signed [POS_W-1:0] target_position;
      logic signed [SPD_W-1:0] target_speed;
   } queue_item_type;

   typedef struct packed {
      logic signed [POS_W-1:0] position;
      logic signed [SPD_W-1:0] speed;
      logic signed [CUR_W-1:0] current;
      logic [TEMP_W-1:0]       temperature;
      logic                    position_near;
      logic                    speed_near;
   } rsp_item_type;

endpackage

// File: sv/motor_feedback_tracker.sv
// motor feedback tracker top level: ports, registers and request packing
//
// one request carries a motor feedback frame; req_tuser is the mode bit
// (0 frame, 1 zero the accumulated position). each request gives exactly
// one response on the rsp_ group with position, speed, current,
// temperature and the two near-target flags.
// csr_we writes lead_mm_q16 (index 0), position_near_band (1) or
// speed_near_band (2); other indexes are ignored. write only while idle.
// throughput: one request per cycle while no response is stalled, set by the
// position accumulator, which updates once per cycle in the back end as it advances.
// a taken request reaches its response through the queue slot, product stage,
// accumulate/divide stage, difference stage and output register.
// when a response waits with rsp_tready low the back end holds; the two-entry
// queue keeps taking requests until full, then req_tready drops.
// reset clears the angle history, the accumulator, the queue and the
// pipeline, and loads the register reset values.
module motor_feedback_tracker import mft_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // rotor_angle, raw_speed, raw_current, temperature_in, target_position,
   // target_speed
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   // mode
   input  logic                   req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // position, speed, current, temperature_out, position_near, speed_near,
   // zero fill
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type        cfg_ff, cfg_in;
   logic           queue_full, queue_empty, push, pop;
   queue_item_type push_item, head_item;
   rsp_item_type   rsp_item;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_LEAD:     cfg_in.lead     = csr_wdata;
            CSR_POS_BAND: cfg_in.pos_band = csr_wdata[BAND_W-1:0];
            CSR_SPD_BAND: cfg_in.spd_band = csr_wdata[BAND_W-1:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.lead     <= LEAD_RESET;
         cfg_ff.pos_band <= POS_BAND_RESET;
         cfg_ff.spd_band <= SPD_BAND_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mft_front u_front (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_tvalid),
      .req_ready           (req_tready),
      .req_mode            (req_tuser),
      .req_angle           (req_tdata[12:0]),
      .req_speed           (req_tdata[28:13]),
      .req_current         (req_tdata[44:29]),
      .req_temperature     (req_tdata[52:45]),
      .req_target_position (req_tdata[100:53]),
      .req_target_speed    (req_tdata[135:101]),
      .queue_full          (queue_full),
      .push                (push),
      .push_item           (push_item)
   );

   mft_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .full      (queue_full),
      .empty     (queue_empty),
      .head_item (head_item)
   );

   mft_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .queue_empty (queue_empty),
      .head_item   (head_item),
      .pop         (pop),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_item    (rsp_item)
   );

   assign rsp_tdata = {4'b0000, rsp_item.speed_near, rsp_item.position_near,
                       rsp_item.temperature, rsp_item.current, rsp_item.speed,
                       rsp_item.position};

endmodule

// File: sv/mft_front.sv
// front end: takes requests, unwraps the angle delta and forms queue entries
module mft_front import mft_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_mode,
   input  logic [ANGLE_W-1:0]       req_angle,
   input  logic signed [RAW_W-1:0]  req_speed,
   input  logic signed [RAW_W-1:0]  req_current,
   input  logic [TEMP_W-1:0]        req_temperature,
   input  logic signed [POS_W-1:0]  req_target_position,
   input  logic signed [SPD_W-1:0]  req_target_speed,
   input  logic                     queue_full,
   output logic                     push,
   output queue_item_type           push_item
);

   localparam logic signed [DELTA_MUL_W-1:0] PCT_S = DELTA_MUL_W'(PCT);
   localparam logic signed [DELTA_MUL_W-1:0] UNWRAP_LIMIT =
      DELTA_MUL_W'(UNWRAP_PCT * COUNTS_PER_REV);
   localparam logic signed [DELTA_W-1:0] REV = DELTA_W'(COUNTS_PER_REV);

   logic [ANGLE_W-1:0]            prev_angle_ff;
   logic [ANGLE_W-1:0]            prev_angle_in;
   logic signed [DELTA_W-1:0]     delta_raw;
   logic signed [DELTA_MUL_W-1:0] delta_ext;
   logic signed [DELTA_MUL_W-1:0] delta_scaled;
   logic signed [DELTA_W-1:0]     delta;
   logic signed [SMAG_W-1:0]      speed_ext;

   assign req_ready = !queue_full;
   assign push      = req_valid && !queue_full;

   always_comb begin
      delta_raw    = $signed({2'b00, req_angle}) - $signed({2'b00, prev_angle_ff});
      delta_ext    = DELTA_MUL_W'(delta_raw);
      delta_scaled = delta_ext * PCT_S;
      priority if (delta_scaled < -UNWRAP_LIMIT) begin
         delta = delta_raw + REV;
      end else if (delta_scaled > UNWRAP_LIMIT) begin
         delta = delta_raw - REV;
      end else begin
         delta = delta_raw;
      end
   end

   always_comb begin
      speed_ext                 = SMAG_W'(req_speed);
      push_item.mode            = req_mode;
      push_item.delta_neg       = delta[DELTA_W-1];
      push_item.delta_mag       = delta[DELTA_W-1] ? DELTA_W'(-delta) : DELTA_W'(delta);
      push_item.speed_neg       = req_speed[RAW_W-1];
      push_item.speed_mag       = req_speed[RAW_W-1] ? SMAG_W'(-speed_ext)
                                                     : SMAG_W'(speed_ext);
      push_item.raw_current     = req_current;
      push_item.temperature     = req_temperature;
      push_item.target_position = req_target_position;
      push_item.target_speed    = req_target_speed;
   end

   // a zero request leaves the previous angle untouched
   assign prev_angle_in = (push && !req_mode) ? req_angle : prev_angle_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_angle_ff <= '0;
      end else begin
         prev_angle_ff <= prev_angle_in;
      end
   end

endmodule

// File: sv/mft_queue.sv
// two-entry queue between the front and back ends
module mft_queue import mft_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  queue_item_type push_item,
   input  logic           pop,
   output logic           full,
   output logic           empty,
   output queue_item_type head_item
);

   queue_item_type mem [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;

   assign full      = count_ff == 2'd2;
   assign empty     = count_ff == 2'd0;
   assign head_item = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: sv/mft_back.sv
// back end: scaling, position accumulation, speed divide and near tests
module mft_back import mft_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  cfg_type        cfg,
   input  logic           queue_empty,
   input  queue_item_type head_item,
   output logic           pop,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output rsp_item_type   rsp_item
);

   localparam logic [PPROD_W:0] ROUND_HALF = (PPROD_W + 1)'(COUNTS_PER_REV / 2);
   localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W - 1){1'b1}}};
   localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W - 1){1'b0}}};
   localparam int HI_PROD_W = DIV_HI_W + DIV_HI_RECIP_W;
   localparam int LO_PART_W = DIV_REM_W + DIV_LO_W;
   localparam int LO_PROD_W = LO_PART_W + DIV_LO_RECIP_W;

   logic advance;

   // stage 1: products
   logic                    v1_ff, mode1_ff, dneg1_ff, sneg1_ff;
   logic [PPROD_W-1:0]      pprod1_ff;
   logic [SPROD_W-1:0]      sprod1_ff;
   logic signed [CUR_W-1:0] cur1_ff;
   logic [TEMP_W-1:0]       temp1_ff;
   logic signed [POS_W-1:0] tpos1_ff;
   logic signed [SPD_W-1:0] tspd1_ff;

   // stage 2: accumulate and divide high part
   logic                    v2_ff, mode2_ff, sneg2_ff;
   logic signed [POS_W-1:0] acc_ff, acc_in;
   logic signed [POS_W-1:0] pos2_ff;
   logic [DIV_HI_Q_W-1:0]   qhi2_ff;
   logic [DIV_REM_W-1:0]    rhi2_ff;
   logic [DIV_LO_W-1:0]     ylo2_ff;
   logic signed [CUR_W-1:0] cur2_ff;
   logic [TEMP_W-1:0]       temp2_ff;
   logic signed [POS_W-1:0] tpos2_ff;
   logic signed [SPD_W-1:0] tspd2_ff;

   // stage 3: divide low part and position difference
   logic                    v3_ff, mode3_ff;
   logic signed [POS_W-1:0] pos3_ff;
   logic signed [SPD_W-1:0] spd3_ff, spd_in;
   logic signed [CUR_W-1:0] cur3_ff;
   logic [TEMP_W-1:0]       temp3_ff;
   logic signed [POS_W:0]   dpos3_ff;
   logic signed [SPD_W-1:0] tspd3_ff;

   // stage 4: output register
   logic                    v4_ff;
   rsp_item_type            out_ff, out_in;

   logic [PPROD_W:0]        round_sum;
   logic [INC_W-2:0]        inc_mag;
   logic signed [INC_W-1:0] inc;
   logic signed [POS_W:0]   pos_sum;
   logic signed [POS_W-1:0] pos_sat;

   logic [DIV_Y_W-1:0]      dy;
   logic [DIV_HI_W-1:0]     dy_hi;
   logic [HI_PROD_W-1:0]    hi_prod;
   logic [DIV_HI_Q_W-1:0]   qhi;
   logic [DIV_HI_W-1:0]     hi_back;
   logic [DIV_REM_W-1:0]    rhi;
   logic [LO_PART_W-1:0]    lo_part;
   logic [LO_PROD_W-1:0]    lo_prod;
   logic [DIV_LO_W-1:0]     qlo;
   logic signed [SPD_W-1:0] spd_mag;

   logic signed [POS_W:0]   pos_lim;
   logic signed [SPD_W:0]   spd_lim;
   logic signed [SPD_W:0]   dspd;

   assign advance   = !(v4_ff && !rsp_ready);
   assign pop       = advance && !queue_empty;
   assign rsp_valid = v4_ff;
   assign rsp_item  = out_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         mode1_ff  <= head_item.mode;
         dneg1_ff  <= head_item.delta_neg;
         sneg1_ff  <= head_item.speed_neg;
         pprod1_ff <= PPROD_W'(head_item.delta_mag) * PPROD_W'(cfg.lead);
         sprod1_ff <= SPROD_W'(head_item.speed_mag) * SPROD_W'(cfg.lead);
         cur1_ff   <= CUR_W'(head_item.raw_current) * CUR_W'(CURRENT_SCALE);
         temp1_ff  <= head_item.temperature;
         tpos1_ff  <= head_item.target_position;
         tspd1_ff  <= head_item.target_speed;
      end
   end

   always_comb begin
      round_sum = {1'b0, pprod1_ff} + ROUND_HALF;
      inc_mag   = (INC_W - 1)'(round_sum >> CPR_SHIFT);
      inc       = dneg1_ff ? -$signed({1'b0, inc_mag}) : $signed({1'b0, inc_mag});
      pos_sum   = (POS_W + 1)'(acc_ff) + (POS_W + 1)'(inc);
      if (pos_sum[POS_W] != pos_sum[POS_W-1]) begin
         pos_sat = pos_sum[POS_W] ? POS_MIN : POS_MAX;
      end else begin
         pos_sat = pos_sum[POS_W-1:0];
      end
      acc_in = mode1_ff ? '0 : pos_sat;
   end

   // high part of the divide by fifteen, quotient and remainder
   always_comb begin
      dy      = sprod1_ff[SPROD_W-1:DIV_PRE_SHIFT];
      dy_hi   = dy[DIV_Y_W-1:DIV_LO_W];
      hi_prod = HI_PROD_W'(dy_hi) * HI_PROD_W'(DIV_HI_RECIP);
      qhi     = hi_prod[DIV_HI_SHIFT +: DIV_HI_Q_W];
      hi_back = dy_hi - DIV_HI_W'(qhi) * DIV_HI_W'(DIV_BASE);
      rhi     = hi_back[DIV_REM_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mode2_ff <= mode1_ff;
         sneg2_ff <= sneg1_ff;
         pos2_ff  <= acc_in;
         qhi2_ff  <= qhi;
         rhi2_ff  <= rhi;
         ylo2_ff  <= dy[DIV_LO_W-1:0];
         cur2_ff  <= mode1_ff ? '0 : cur1_ff;
         temp2_ff <= mode1_ff ? '0 : temp1_ff;
         tpos2_ff <= tpos1_ff;
         tspd2_ff <= tspd1_ff;
      end
   end

   // low part of the divide by fifteen
   always_comb begin
      lo_part = {rhi2_ff, ylo2_ff};
      lo_prod = LO_PROD_W'(lo_part) * LO_PROD_W'(DIV_LO_RECIP);
      qlo     = lo_prod[DIV_LO_SHIFT +: DIV_LO_W];
      spd_mag = SPD_W'({qhi2_ff, qlo});
      spd_in  = sneg2_ff ? -spd_mag : spd_mag;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mode3_ff <= mode2_ff;
         pos3_ff  <= pos2_ff;
         spd3_ff  <= mode2_ff ? '0 : spd_in;
         cur3_ff  <= cur2_ff;
         temp3_ff <= temp2_ff;
         dpos3_ff <= (POS_W + 1)'(pos2_ff) - (POS_W + 1)'(tpos2_ff);
         tspd3_ff <= tspd2_ff;
      end
   end

   // strict band test, both sides of zero
   always_comb begin
      pos_lim              = $signed((POS_W + 1)'({cfg.pos_band, {BAND_SHIFT{1'b0}}}));
      spd_lim              = $signed((SPD_W + 1)'({cfg.spd_band, {BAND_SHIFT{1'b0}}}));
      dspd                 = (SPD_W + 1)'(spd3_ff) - (SPD_W + 1)'(tspd3_ff);
      out_in.position      = pos3_ff;
      out_in.speed         = spd3_ff;
      out_in.current       = cur3_ff;
      out_in.temperature   = temp3_ff;
      out_in.position_near = !mode3_ff && (dpos3_ff < pos_lim) && (dpos3_ff > -pos_lim);
      out_in.speed_near    = !mode3_ff && (dspd < spd_lim) && (dspd > -spd_lim);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= out_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
         v3_ff  <= 1'b0;
         v4_ff  <= 1'b0;
         acc_ff <= '0;
      end else if (advance) begin
         v1_ff <= !queue_empty;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         if (v1_ff) begin
            acc_ff <= acc_in;
         end
      end
   end

endmodule

// File: sv/mft_checker.sv
// port-level checks on the motor feedback tracker, bound to the top level
module mft_checker import mft_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tready,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_DATA_W-1:0]  rsp_tdata
);

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // after reset nothing pending and the queue takes requests
   a_reset_state: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("bad state after reset");

   // current is raw times 80, so its low four bits and the fill stay zero
   a_current_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[86:83] == 4'b0000 && rsp_tdata[119:116] == 4'b0000)
      else $error("current low bits or fill not zero");

   // the queue only fills while a response is waiting
   a_ready_drop: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("request side blocked with no response waiting");

endmodule

bind motor_feedback_tracker mft_checker u_mft_checker (.*);

// File: dv/tb.sv
// testbench for the motor feedback tracker: random and directed frames checked by a scoreboard
module tb;
   import mft_pkg::*;

   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;
   localparam longint POS_HI = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint POS_LO = -POS_HI - 1;

   class feedback_scoreboard;
      logic [LEAD_W-1:0] lead;
      logic [BAND_W-1:0] pos_band;
      logic [BAND_W-1:0] spd_band;
      logic [15:0]       prev_angle;
      longint            accum;
      rsp_item_type      expected_rsp[$];
      int                errors;
      int                checked;

      function new();
         lead       = LEAD_RESET;
         pos_band   = POS_BAND_RESET;
         spd_band   = SPD_BAND_RESET;
         prev_angle = '0;
         accum      = 0;
         errors     = 0;
         checked    = 0;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
         case (index)
            CSR_LEAD:     lead = value;
            CSR_POS_BAND: pos_band = value[BAND_W-1:0];
            CSR_SPD_BAND: spd_band = value[BAND_W-1:0];
            default: ;
         endcase
      endfunction

      // unwrapped, scaled and saturated position for the next frame
      function longint position_after(logic [ANGLE_W-1:0] angle);
         longint delta;
         longint mag;
         longint pos;
         delta = longint'(angle) - longint'(prev_angle);
         if (delta * 100 < -66 * COUNTS_PER_REV) delta += COUNTS_PER_REV;
         else if (delta * 100 > 66 * COUNTS_PER_REV) delta -= COUNTS_PER_REV;
         mag = (delta < 0) ? -delta : delta;
         mag = (mag * longint'(lead) + COUNTS_PER_REV / 2) / COUNTS_PER_REV;
         pos = accum + ((delta < 0) ? -mag : mag);
         if (pos > POS_HI) pos = POS_HI;
         if (pos < POS_LO) pos = POS_LO;
         return pos;
      endfunction

      function longint speed_of(logic signed [RAW_W-1:0] rs);
         longint mag;
         mag = ((rs < 0) ? -longint'(rs) : longint'(rs)) * longint'(lead) / 60;
         return (rs < 0) ? -mag : mag;
      endfunction

      function void note_request(logic mode, logic [REQ_DATA_W-1:0] d);
         rsp_item_type            e;
         longint                  pos;
         longint                  spd;
         longint                  cur;
         longint                  dp;
         longint                  ds;
         logic signed [RAW_W-1:0] rc;
         e = '0;
         if (mode) begin
            accum = 0;
         end else begin
            pos        = position_after(d[12:0]);
            accum      = pos;
            prev_angle = {3'b000, d[12:0]};
            spd        = speed_of(d[28:13]);
            rc         = d[44:29];
            cur        = longint'(rc) * 80;
            dp         = pos - longint'($signed(d[100:53]));
            ds         = spd - longint'($signed(d[135:101]));
            if (dp < 0) dp = -dp;
            if (ds < 0) ds = -ds;
            e.position      = pos[POS_W-1:0];
            e.speed         = spd[SPD_W-1:0];
            e.current       = cur[CUR_W-1:0];
            e.temperature   = d[52:45];
            e.position_near = (dp < (longint'(pos_band) << 16));
            e.speed_near    = (ds < (longint'(spd_band) << 16));
         end
         expected_rsp.push_back(e);
      endfunction

      function void check_response(logic [RSP_DATA_W-1:0] d);
         rsp_item_type e;
         checked++;
         if (expected_rsp.size() == 0) begin
            $error("response with no request waiting");
            errors++;
            return;
         end
         e = expected_rsp.pop_front();
         if (d[47:0] !== e.position) begin
            $error("position: expected %0d, actual %0d", e.position, $signed(d[47:0]));
            errors++;
         end
         if (d[82:48] !== e.speed) begin
            $error("speed: expected %0d, actual %0d", e.speed, $signed(d[82:48]));
            errors++;
         end
         if (d[105:83] !== e.current) begin
            $error("current: expected %0d, actual %0d", e.current, $signed(d[105:83]));
            errors++;
         end
         if (d[113:106] !== e.temperature) begin
            $error("temperature_out: expected %0d, actual %0d", e.temperature, d[113:106]);
            errors++;
         end
         if (d[114] !== e.position_near) begin
            $error("position_near: expected %0d, actual %0d", e.position_near, d[114]);
            errors++;
         end
         if (d[115] !== e.speed_near) begin
            $error("speed_near: expected %0d, actual %0d", e.speed_near, d[115]);
            errors++;
         end
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata = '0;
   logic                   req_tuser = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   feedback_scoreboard sb;
   bit quiet = 1'b0;
   int sent = 0;
   int clears = 0;
   int settings = 0;

   motor_feedback_tracker u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      rsp_tready <= quiet || ($urandom_range(0, 99) >= 20);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_response(rsp_tdata);
      end
   end

   function automatic logic [REQ_DATA_W-1:0] pack_frame(
      logic [ANGLE_W-1:0] angle, logic [RAW_W-1:0] rs, logic [RAW_W-1:0] rc,
      logic [TEMP_W-1:0] temp, logic [POS_W-1:0] tpos, logic [SPD_W-1:0] tspd);
      return {tspd, tpos, temp, rc, rs, angle};
   endfunction

   function automatic longint near_offset(longint bq);
      case ($urandom_range(0, 5))
         0: return bq;
         1: return -bq;
         2: return bq - 1;
         3: return 1 - bq;
         default: return longint'($urandom_range(0, 32'(4 * bq + 4))) - (2 * bq + 2);
      endcase
   endfunction

   task automatic send(input logic mode, input logic [REQ_DATA_W-1:0] data);
      if (!quiet && $urandom_range(0, 99) < 20) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 2)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(mode, data);
      sent++;
      if (mode) clears++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.expected_rsp.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      sb.write_reg(index, value);
   endtask

   task automatic configure(input logic [LEAD_W-1:0] lead, input logic [BAND_W-1:0] pb,
                            input logic [BAND_W-1:0] spb);
      write_reg(CSR_LEAD, lead);
      write_reg(CSR_POS_BAND, {16'h0000, pb});
      write_reg(CSR_SPD_BAND, {16'h0000, spb});
      write_reg(CSR_UNUSED, 24'($urandom));
      csr_we <= 1'b0;
      settings++;
   endtask

   // frames that sit exactly on and just inside both near bands
   task automatic probe_bands();
      longint p;
      longint s;
      longint bq;
      longint sq;
      longint tp;
      longint ts;
      logic [ANGLE_W-1:0] a;
      a  = sb.prev_angle[ANGLE_W-1:0];
      p  = sb.accum;
      s  = sb.speed_of(16'sd1000);
      bq = longint'(sb.pos_band) << 16;
      sq = longint'(sb.spd_band) << 16;
      tp = p + bq;
      ts = s - sq;
      send(1'b0, pack_frame(a, 16'd1000, 16'd7, 8'd33, tp[47:0], ts[34:0]));
      tp = p + bq - 1;
      ts = s + sq - 1;
      send(1'b0, pack_frame(a, 16'd1000, 16'd7, 8'd33, tp[47:0], ts[34:0]));
      tp = p - bq;
      ts = s + sq;
      send(1'b0, pack_frame(a, 16'd1000, 16'd7, 8'd33, tp[47:0], ts[34:0]));
   endtask

   task automatic send_random();
      logic               mode;
      logic [ANGLE_W-1:0] angle;
      logic [RAW_W-1:0]   rs;
      logic [RAW_W-1:0]   rc;
      logic [63:0]        r;
      longint             tp;
      longint             ts;
      int                 a;
      int                 off;
      int                 pick;
      mode = ($urandom_range(0, 99) < 3);
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
         a = int'(sb.prev_angle) + $urandom_range(0, 600) - 300;
         angle = a[ANGLE_W-1:0];
      end else if (pick < 7) begin
         // deltas around the unwrap threshold
         off = $urandom_range(5400, 5412);
         a = int'(sb.prev_angle) + off;
         if (a > 8191) a = int'(sb.prev_angle) - off;
         if (a < 0) a = $urandom_range(0, 8191);
         angle = a[ANGLE_W-1:0];
      end else begin
         angle = 13'($urandom);
      end
      case ($urandom_range(0, 9))
         0: rs = 16'h7FFF;
         1: rs = 16'h8000;
         2: rs = 16'($urandom_range(0, 200)) - 16'd100;
         default: rs = 16'($urandom);
      endcase
      case ($urandom_range(0, 9))
         0: rc = 16'h7FFF;
         1: rc = 16'h8000;
         default: rc = 16'($urandom);
      endcase
      r = {$urandom, $urandom};
      if (!mode && $urandom_range(0, 99) < 40) begin
         tp = sb.position_after(angle) + near_offset(longint'(sb.pos_band) << 16);
      end else begin
         tp = longint'(r);
      end
      r = {$urandom, $urandom};
      if (!mode && $urandom_range(0, 99) < 40) begin
         ts = sb.speed_of(rs) + near_offset(longint'(sb.spd_band) << 16);
      end else begin
         ts = longint'(r);
      end
      send(mode, pack_frame(angle, rs, rc, 8'($urandom), tp[47:0], ts[34:0]));
   endtask

   task automatic run_phase(input int n, input logic [LEAD_W-1:0] lead,
                            input logic [BAND_W-1:0] pb, input logic [BAND_W-1:0] spb,
                            input bit stretch);
      drain();
      configure(lead, pb, spb);
      for (int i = 0; i < n; i++) begin
         quiet = stretch && (i >= n / 4) && (i < 3 * n / 4);
         send_random();
      end
      quiet = 1'b0;
   endtask

   initial begin
      sb = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset register values, unwrap thresholds and field extremes
      send(1'b0, '0);
      send(1'b0, pack_frame(13'd5406, 16'h7FFF, 16'h8000, 8'hFF,
                            48'h7FFF_FFFF_FFFF, 35'h4_0000_0000));
      send(1'b0, pack_frame(13'd0, 16'h8000, 16'h7FFF, 8'h00,
                            48'h8000_0000_0000, 35'h3_FFFF_FFFF));
      send(1'b0, pack_frame(13'd5407, 16'd0, 16'd0, 8'd1, '0, '0));
      send(1'b0, pack_frame(13'd0, 16'd1, 16'hFFFF, 8'd2, '0, '0));
      send(1'b0, pack_frame(13'd8191, 16'hFFFF, 16'd1, 8'd3, '1, '1));
      send(1'b0, pack_frame(13'd0, 16'd60, 16'd819, 8'd4, '0, '0));
      send(1'b1, {$urandom, $urandom, $urandom, $urandom, 8'($urandom)});
      probe_bands();

      // zero lead and zero bands
      drain();
      configure(24'd0, 8'd0, 8'd0);
      send(1'b0, pack_frame(13'd4000, 16'h7FFF, 16'd5, 8'd9,
                            sb.accum[47:0], 35'd0));
      send(1'b0, pack_frame(13'd100, 16'h8000, 16'd5, 8'd9, sb.accum[47:0], 35'd0));

      // widest lead and bands
      drain();
      configure(24'hFF_FFFF, 8'hFF, 8'hFF);
      send(1'b0, pack_frame(13'd5506, 16'h7FFF, 16'h7FFF, 8'hAA, '0, '0));
      send(1'b0, pack_frame(13'd0, 16'h8000, 16'h8000, 8'h55, '1, '1));
      probe_bands();
      send(1'b1, '0);

      run_phase(266, LEAD_RESET, POS_BAND_RESET, SPD_BAND_RESET, 1'b0);
      run_phase(266, 24'($urandom), 8'($urandom), 8'($urandom), 1'b1);
      run_phase(266, 24'hFF_FFFF, 8'hFF, 8'hFF, 1'b0);
      run_phase(266, 24'd1, 8'd0, 8'd0, 1'b0);
      run_phase(266, 24'($urandom), 8'($urandom_range(0, 3)), 8'($urandom), 1'b0);
      drain();

      $display("covered %0d frames including %0d position clears under %0d register settings,",
               sent, clears, settings);
      $display("with unwrap thresholds, near-band edges and random stalls; %0d responses checked",
               sb.checked);
      if (sb.errors == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("tb: FAIL");
      $finish;
   end

endmodule
